[hw/rtl/cofd_pkg.sv]
// Shared types and constants for the clock offset minimum-dispersion filter.
package cofd_pkg;

  // Packet type code of a timing reply
  localparam logic [7:0] REPLY_TYPE = 8'hD3;

  // Aging divide by 100 runs as long division in 16-bit digits
  localparam int unsigned DIGIT_W     = 16;
  localparam int unsigned DIGITS      = 64 / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGITS);
  // Partial dividend per digit: remainder (< 100, 7 bits) and one digit
  localparam int unsigned REM_W       = 7;
  localparam int unsigned PART_W      = REM_W + DIGIT_W;
  // floor(v / 100) = (v * ceil(2^30 / 100)) >> 30, exact for v < 100 * 2^16
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int unsigned EST_W       = PART_W + RECIP_W;

  typedef struct packed {
    logic [63:0] offset;
    logic [63:0] disp;
  } hist_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWOFF,
    ST_READ,
    ST_AGE,
    ST_WAIT,
    ST_STEP,
    ST_OUT
  } cofd_state_e;

endpackage

[hw/rtl/cofd_hist_ram.sv]
// History memory: one write port, one read port, registered read data.
module cofd_hist_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  cofd_pkg::hist_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output cofd_pkg::hist_entry_t rdata_o
);
  import cofd_pkg::*;

  hist_entry_t mem_q [DEPTH];
  hist_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cofd_age_unit.sv]
// Dispersion aging unit: (d * 110 mod 2^64) / 100, one 16-bit quotient digit per cycle.
module cofd_age_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] disp_i,
  output logic        done_o,
  output logic [63:0] aged_o
);
  import cofd_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]            prod_q, prod_d;
  logic [63:0]            quo_q, quo_d;
  logic [REM_W-1:0]       rem_q, rem_d;

  logic [63:0]            mul110;
  logic [PART_W-1:0]      part;
  logic [EST_W-1:0]       est;
  logic [DIGIT_W-1:0]     qd;
  logic [PART_W-1:0]      back;
  logic [PART_W-1:0]      rem_full;

  // 110 = 128 - 16 - 2
  assign mul110 = (disp_i << 7) - (disp_i << 4) - (disp_i << 1);

  assign part     = {rem_q, prod_q[63 -: DIGIT_W]};
  assign est      = EST_W'(part) * EST_W'(RECIP);
  assign qd       = est[RECIP_SHIFT +: DIGIT_W];
  // qd * 100 = qd * (64 + 32 + 4)
  assign back     = (PART_W'(qd) << 6) + (PART_W'(qd) << 5) + (PART_W'(qd) << 2);
  assign rem_full = part - back;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      prod_d = mul110;
      rem_d  = '0;
    end else if (busy_q) begin
      prod_d = prod_q << DIGIT_W;
      quo_d  = {quo_q[63-DIGIT_W:0], qd};
      rem_d  = rem_full[REM_W-1:0];
      cnt_d  = cnt_q + DIGIT_CNT_W'(1);
      if (cnt_q == DIGIT_CNT_W'(DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign aged_o = quo_q;

endmodule

[hw/rtl/clock_offset_min_dispersion_filter_core.sv]
// Top level of the clock offset filter: control sequencer, history memory, result register.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one timing reply per transfer:
//    packet type, arrival, departure and remote transmit times (32.32 fixed point).
//    Types other than 0xd3 are taken and dropped with no result.
//  - Output channel (out_valid_o / out_stall_i) carries one result per timing reply:
//    chosen offset, its history slot and aged dispersion, offset step, jitter
//    sum and count, and the number of filled history entries.
//  - History lives in a ring buffer memory with registered read data; the head moves
//    back one entry per reply, so shifting costs nothing. Every filled older entry
//    is read, aged by the iterative divide-by-100 unit, written back and compared.
//  - The result follows the input transfer after the new entry write, the work on each
//    older entry and the offset step; the next reply is taken once the result is loaded.
//    Each older entry costs read, aging start, four quotient digits and write back.
//  - One reply is in work at a time; in_stall_o is high while it runs. A new reply
//    may be taken while the previous result is still waiting in the output register.
//  - If the receiver stalls, the result holds steady and the sequencer waits in
//    its final state until the output register frees up.
//  - Reset clears the fill count, current offset and jitter totals. Memory contents
//    are not cleared: only entries written since reset are ever read.
module clock_offset_min_dispersion_filter_core #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         packet_type_i,
  input  logic [63:0]        arrival_time_i,
  input  logic [63:0]        departure_time_i,
  input  logic [63:0]        remote_transmit_time_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        offset_o,
  output logic [5:0]         chosen_slot_o,
  output logic [63:0]        chosen_dispersion_o,
  output logic signed [63:0] offset_step_o,
  output logic [63:0]        jitter_total_o,
  output logic [31:0]        jitter_samples_o,
  output logic [6:0]         filled_o
);
  import cofd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);

  // ring pointer step with wrap for any depth
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(HISTORY_DEPTH - 1)) r = '0;
    else r = p + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) r = AW'(HISTORY_DEPTH - 1);
    else r = p - AW'(1);
    return r;
  endfunction

  cofd_state_e state_q, state_d;

  // architectural state
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [63:0]   cur_off_q, cur_off_d;
  logic [63:0]   jit_sum_q, jit_sum_d;
  logic [31:0]   jit_cnt_q, jit_cnt_d;

  // per-reply work registers
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] k_q, k_d;
  logic [63:0]   trip_q, trip_d;
  logic [63:0]   diff_q, diff_d;
  logic [63:0]   rd_off_q, rd_off_d;
  logic [63:0]   best_off_q, best_off_d;
  logic [63:0]   best_disp_q, best_disp_d;
  logic [AW-1:0] best_slot_q, best_slot_d;
  logic [63:0]   step_q, step_d;
  logic [63:0]   abs_q, abs_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [63:0]   o_off_q, o_disp_q, o_step_q, o_jsum_q;
  logic [5:0]    o_slot_q;
  logic [31:0]   o_jcnt_q;
  logic [6:0]    o_fill_q;

  // memory and aging unit hookup
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  hist_entry_t   ram_wdata, ram_rdata;
  logic          age_start, age_done;
  logic [63:0]   aged;

  logic [AW-1:0] head_new;
  logic [FW-1:0] fill_new;
  logic [63:0]   new_off;
  logic          out_free;
  logic          multi;

  assign head_new = ptr_dec(head_q);
  assign fill_new = (fill_q == FW'(HISTORY_DEPTH)) ? fill_q : fill_q + FW'(1);
  assign new_off  = diff_q + {1'b0, trip_q[63:1]};
  assign out_free = !out_valid_q || !out_stall_i;
  assign multi    = (fill_q > FW'(1));

  cofd_hist_ram #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cofd_age_unit u_age (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(age_start),
    .disp_i (ram_rdata.disp),
    .done_o (age_done),
    .aged_o (aged)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    cur_off_d   = cur_off_q;
    jit_sum_d   = jit_sum_q;
    jit_cnt_d   = jit_cnt_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    trip_d      = trip_q;
    diff_d      = diff_q;
    rd_off_d    = rd_off_q;
    best_off_d  = best_off_q;
    best_disp_d = best_disp_q;
    best_slot_d = best_slot_q;
    step_d      = step_q;
    abs_d       = abs_q;
    out_load    = 1'b0;
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = '{offset: rd_off_q, disp: aged};
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;
    age_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && (packet_type_i == REPLY_TYPE)) begin
          trip_d  = arrival_time_i - departure_time_i;
          diff_d  = remote_transmit_time_i - arrival_time_i;
          state_d = ST_NEWOFF;
        end
      end
      ST_NEWOFF: begin
        // newest entry lands at the new head; older entries keep their slots
        ram_we      = 1'b1;
        ram_waddr   = head_new;
        ram_wdata   = '{offset: new_off, disp: trip_q};
        head_d      = head_new;
        fill_d      = fill_new;
        best_off_d  = new_off;
        best_disp_d = trip_q;
        best_slot_d = '0;
        ptr_d       = ptr_inc(head_new);
        k_d         = AW'(1);
        state_d     = (fill_new > FW'(1)) ? ST_READ : ST_STEP;
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_AGE;
      end
      ST_AGE: begin
        age_start = 1'b1;
        rd_off_d  = ram_rdata.offset;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (age_done) begin
          ram_we = 1'b1;
          // strict compare: the newer entry keeps a tie
          if (aged < best_disp_q) begin
            best_off_d  = rd_off_q;
            best_disp_d = aged;
            best_slot_d = k_q;
          end
          ptr_d = ptr_inc(ptr_q);
          k_d   = k_q + AW'(1);
          if ((FW'(k_q) + FW'(1)) == fill_q) state_d = ST_STEP;
          else state_d = ST_READ;
        end
      end
      ST_STEP: begin
        step_d  = best_off_q - cur_off_q;
        abs_d   = (best_off_q > cur_off_q) ? (best_off_q - cur_off_q)
                                           : (cur_off_q - best_off_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          cur_off_d = best_off_q;
          if (multi) begin
            jit_sum_d = jit_sum_q + abs_q;
            jit_cnt_d = jit_cnt_q + 32'd1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      cur_off_q   <= '0;
      jit_sum_q   <= '0;
      jit_cnt_q   <= '0;
      ptr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      cur_off_q   <= cur_off_d;
      jit_sum_q   <= jit_sum_d;
      jit_cnt_q   <= jit_cnt_d;
      ptr_q       <= ptr_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trip_q      <= trip_d;
    diff_q      <= diff_d;
    rd_off_q    <= rd_off_d;
    best_off_q  <= best_off_d;
    best_disp_q <= best_disp_d;
    best_slot_q <= best_slot_d;
    step_q      <= step_d;
    abs_q       <= abs_d;
    if (out_load) begin
      o_off_q  <= best_off_q;
      o_slot_q <= 6'(best_slot_q);
      o_disp_q <= best_disp_q;
      o_step_q <= multi ? step_q : 64'd0;
      o_jsum_q <= jit_sum_d;
      o_jcnt_q <= jit_cnt_d;
      o_fill_q <= 7'(fill_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign offset_o            = o_off_q;
  assign chosen_slot_o       = o_slot_q;
  assign chosen_dispersion_o = o_disp_q;
  assign offset_step_o       = o_step_q;
  assign jitter_total_o      = o_jsum_q;
  assign jitter_samples_o    = o_jcnt_q;
  assign filled_o            = o_fill_q;

  // fill count never passes the history depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  // write-back and read never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("memory read and write to the same entry");

  // chosen entry is always a filled one
  a_slot_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (FW'(best_slot_q) < fill_q))
    else $error("chosen slot outside filled history");

  // the aging result only comes back while the sequencer waits for it
  a_age_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_done |-> (state_q == ST_WAIT))
    else $error("aging result outside wait state");

  // a new result is loaded only into a free output register
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule
